// ===== rtl/rhse_pkg.sv =====
// Shared constants, command codes and the queued command word type.
package rhse_pkg;

    localparam logic [60:0] MOD61 = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [60:0] BASE_RESET = 61'd998244353;
    localparam int MAX_LEN_DEFAULT = 4096;
    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] CMD_APPEND_TEXT = 3'd0;
    localparam logic [2:0] CMD_QUERY = 3'd1;
    localparam logic [2:0] CMD_APPEND_PAT = 3'd2;
    localparam logic [2:0] CMD_FIND = 3'd3;
    localparam logic [2:0] CMD_CLEAR_PAT = 3'd4;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd5;

    typedef enum logic [2:0] {
        OP_APPEND_TEXT,
        OP_QUERY,
        OP_APPEND_PAT,
        OP_FIND,
        OP_CLEAR_PAT,
        OP_CLEAR_ALL,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [12:0] pos_l;
        logic [12:0] pos_r;
    } item_t;

endpackage

// ===== rtl/rhse_front.sv =====
// Command front end: decodes each command word and queues it for the executor.
module rhse_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     cmd,
    input  logic [7:0]     ch,
    input  logic [12:0]    pos_l,
    input  logic [12:0]    pos_r,
    output logic           busy,
    output logic           q_valid,
    output rhse_pkg::item_t q_item,
    input  logic           q_pop
);
    import rhse_pkg::*;

    item_t slot_reg [FIFO_DEPTH];
    logic  rd_ptr_reg;
    logic  wr_ptr_reg;
    logic [1:0] count_reg;
    item_t in_item;
    logic  push;

    // Classify the raw command code.
    always_comb
    begin
        in_item.ch = ch;
        in_item.pos_l = pos_l;
        in_item.pos_r = pos_r;
        case (cmd)
            CMD_APPEND_TEXT: in_item.op = OP_APPEND_TEXT;
            CMD_QUERY:       in_item.op = OP_QUERY;
            CMD_APPEND_PAT:  in_item.op = OP_APPEND_PAT;
            CMD_FIND:        in_item.op = OP_FIND;
            CMD_CLEAR_PAT:   in_item.op = OP_CLEAR_PAT;
            CMD_CLEAR_ALL:   in_item.op = OP_CLEAR_ALL;
            default:         in_item.op = OP_BAD;
        endcase
    end

    assign busy = (count_reg == 2'(FIFO_DEPTH));
    assign push = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    // Two-entry word queue.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

// ===== rtl/rhse_mulmod.sv =====
// Iterative modular multiplier modulo 2^61-1, one 31x31 partial product per cycle.
module rhse_mulmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [60:0] a,
    input  logic [60:0] b,
    output logic        done,
    output logic [60:0] result
);
    import rhse_pkg::*;

    logic [60:0]  a_reg;
    logic [60:0]  b_reg;
    logic [2:0]   cnt_reg;
    logic         run_reg;
    logic         fold_reg;
    logic         pv_reg;
    logic [61:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [121:0] acc_reg;
    logic         done_reg;
    logic [60:0]  result_reg;
    logic [30:0]  x;
    logic [30:0]  y;
    logic [121:0] pp_shifted;
    logic [61:0]  fsum;

    // Operand halves for the current partial product.
    assign x = cnt_reg[0] ? {1'b0, a_reg[60:31]} : a_reg[30:0];
    assign y = cnt_reg[1] ? {1'b0, b_reg[60:31]} : b_reg[30:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = {60'd0, pp_reg};
            2'd1:    pp_shifted = {29'd0, pp_reg, 31'd0};
            default: pp_shifted = {pp_reg[59:0], 62'd0};
        endcase
    end

    // Mersenne fold: high part added onto the low part, then one subtract.
    assign fsum = {1'b0, acc_reg[60:0]} + {1'b0, acc_reg[121:61]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            run_reg <= 1'b0;
            fold_reg <= 1'b0;
            pv_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg <= a;
                b_reg <= b;
                cnt_reg <= 3'd0;
                run_reg <= 1'b1;
                pv_reg <= 1'b0;
                acc_reg <= '0;
            end
            else if (run_reg)
            begin
                if (pv_reg)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                if (cnt_reg == 3'd4)
                begin
                    run_reg <= 1'b0;
                    fold_reg <= 1'b1;
                    pv_reg <= 1'b0;
                end
                else
                begin
                    pp_reg <= x * y;
                    sh_reg <= 2'({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]});
                    pv_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
            else if (fold_reg)
            begin
                fold_reg <= 1'b0;
                done_reg <= 1'b1;
                result_reg <= (fsum >= {1'b0, MOD61}) ? 61'(fsum - {1'b0, MOD61})
                                                      : fsum[60:0];
            end
        end
    end

    assign done = done_reg;
    assign result = result_reg;
endmodule

// ===== rtl/rhse_back.sv =====
// Command executor: prefix and power stores, span hashing and the find scan.
module rhse_back #(
    parameter int MAX_LEN = rhse_pkg::MAX_LEN_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [60:0]     base,
    input  logic            q_valid,
    input  rhse_pkg::item_t q_item,
    output logic            q_pop,
    output logic            done,
    output logic [60:0]     hash_value,
    output logic signed [13:0] position,
    output logic            error
);
    import rhse_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = LW;
    localparam int CW = ((LW > 13) ? LW : 13) + 1;
    localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

    typedef enum logic [3:0] {
        S_IDLE, S_TXT_H, S_TXT_P, S_PAT, S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_SPAN
    } state_t;

    state_t state_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] plen_reg;
    logic [60:0]   phash_reg;
    logic [60:0]   cur_h_reg;
    logic [60:0]   cur_p_reg;
    logic [60:0]   th_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [60:0]   hl_reg;
    logic [60:0]   pw_reg;
    logic [60:0]   hr_reg;
    logic          find_reg;
    logic [AW-1:0] ha_reg;
    logic [AW-1:0] pa_reg;
    logic          we_reg;
    logic [AW-1:0] wa_reg;
    logic [60:0]   wdh_reg;
    logic [60:0]   wdp_reg;
    logic          mstart_reg;
    logic [60:0]   ma_reg;
    logic [60:0]   mb_reg;
    logic          done_reg;
    logic [60:0]   hv_reg;
    logic [13:0]   pos_reg;
    logic          err_reg;
    logic [7:0]    q_item_ch_hold;

    logic [60:0] hmem [0:MAX_LEN];
    logic [60:0] pmem [0:MAX_LEN];
    logic [60:0] hrd_reg;
    logic [60:0] prd_reg;
    logic        hz_reg;
    logic        pz_reg;
    logic [60:0] hrd;
    logic [60:0] prd;

    logic        mdone;
    logic [60:0] mres;
    logic [61:0] chsum;
    logic [60:0] chval;
    logic [62:0] span_sum;
    logic [60:0] span;
    logic [CW-1:0] l_ext;
    logic [CW-1:0] r_ext;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] plen_ext;
    logic [CW-1:0] find_end;
    logic [CW-1:0] next_lo;

    rhse_mulmod u_mul (
        .clk(clk), .rst_n(rst_n), .start(mstart_reg), .a(ma_reg), .b(mb_reg),
        .done(mdone), .result(mres)
    );

    // Stores: entry 0 reads as its reset value and is never written.
    always_ff @(posedge clk)
    begin
        if (we_reg)
        begin
            hmem[wa_reg] <= wdh_reg;
            pmem[wa_reg] <= wdp_reg;
        end
        hrd_reg <= hmem[ha_reg];
        prd_reg <= pmem[pa_reg];
        hz_reg <= (ha_reg == '0);
        pz_reg <= (pa_reg == '0);
    end

    assign hrd = hz_reg ? 61'd0 : hrd_reg;
    assign prd = pz_reg ? 61'd1 : prd_reg;

    // Datapath helpers.
    assign chsum = {1'b0, mres} + {54'd0, q_item_ch_hold};
    assign chval = (chsum >= {1'b0, MOD61}) ? 61'(chsum - {1'b0, MOD61}) : chsum[60:0];
    assign span_sum = {2'b0, hr_reg} + {2'b0, MOD61} - {2'b0, mres};
    assign span = (span_sum >= {2'b0, MOD61}) ? 61'(span_sum - {2'b0, MOD61})
                                              : span_sum[60:0];
    assign l_ext = CW'(q_item.pos_l);
    assign r_ext = CW'(q_item.pos_r);
    assign len_ext = CW'(len_reg);
    assign plen_ext = CW'(plen_reg);
    assign find_end = l_ext + plen_ext;
    assign next_lo = lo_reg + CW'(1);

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // Sequencer with registered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            plen_reg <= '0;
            phash_reg <= '0;
            cur_h_reg <= '0;
            cur_p_reg <= 61'd1;
            we_reg <= 1'b0;
            mstart_reg <= 1'b0;
            done_reg <= 1'b0;
            find_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            we_reg <= 1'b0;
            mstart_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        hv_reg <= '0;
                        pos_reg <= '0;
                        err_reg <= 1'b0;
                        q_item_ch_hold <= q_item.ch;
                        case (q_item.op)
                            OP_APPEND_TEXT:
                            begin
                                if (len_reg == FULL)
                                begin
                                    err_reg <= 1'b1;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    ma_reg <= cur_h_reg;
                                    mb_reg <= base;
                                    mstart_reg <= 1'b1;
                                    state_reg <= S_TXT_H;
                                end
                            end
                            OP_APPEND_PAT:
                            begin
                                if (plen_reg == FULL)
                                begin
                                    err_reg <= 1'b1;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    ma_reg <= phash_reg;
                                    mb_reg <= base;
                                    mstart_reg <= 1'b1;
                                    state_reg <= S_PAT;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (l_ext <= r_ext && r_ext <= len_ext)
                                begin
                                    lo_reg <= l_ext;
                                    hi_reg <= r_ext;
                                    ha_reg <= l_ext[AW-1:0];
                                    pa_reg <= AW'(r_ext - l_ext);
                                    find_reg <= 1'b0;
                                    state_reg <= S_RD_A;
                                end
                                else
                                begin
                                    err_reg <= 1'b1;
                                    done_reg <= 1'b1;
                                end
                            end
                            OP_FIND:
                            begin
                                if (find_end > len_ext)
                                begin
                                    pos_reg <= '1;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    lo_reg <= l_ext;
                                    hi_reg <= find_end;
                                    ha_reg <= l_ext[AW-1:0];
                                    pa_reg <= plen_reg;
                                    find_reg <= 1'b1;
                                    state_reg <= S_RD_A;
                                end
                            end
                            OP_CLEAR_PAT:
                            begin
                                phash_reg <= '0;
                                plen_reg <= '0;
                                done_reg <= 1'b1;
                            end
                            OP_CLEAR_ALL:
                            begin
                                phash_reg <= '0;
                                plen_reg <= '0;
                                len_reg <= '0;
                                cur_h_reg <= '0;
                                cur_p_reg <= 61'd1;
                                done_reg <= 1'b1;
                            end
                            default:
                            begin
                                err_reg <= 1'b1;
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_TXT_H:
                begin
                    if (mdone)
                    begin
                        th_reg <= chval;
                        ma_reg <= cur_p_reg;
                        mb_reg <= base;
                        mstart_reg <= 1'b1;
                        state_reg <= S_TXT_P;
                    end
                end
                S_TXT_P:
                begin
                    if (mdone)
                    begin
                        we_reg <= 1'b1;
                        wa_reg <= AW'(len_reg + LW'(1));
                        wdh_reg <= th_reg;
                        wdp_reg <= mres;
                        cur_h_reg <= th_reg;
                        cur_p_reg <= mres;
                        len_reg <= len_reg + LW'(1);
                        hv_reg <= th_reg;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_PAT:
                begin
                    if (mdone)
                    begin
                        phash_reg <= chval;
                        plen_reg <= plen_reg + LW'(1);
                        hv_reg <= chval;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD_A:
                begin
                    state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    hl_reg <= hrd;
                    pw_reg <= prd;
                    ha_reg <= hi_reg[AW-1:0];
                    state_reg <= S_RD_C;
                end
                S_RD_C:
                begin
                    state_reg <= S_RD_D;
                end
                S_RD_D:
                begin
                    hr_reg <= hrd;
                    ma_reg <= hl_reg;
                    mb_reg <= pw_reg;
                    mstart_reg <= 1'b1;
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    if (mdone)
                    begin
                        if (!find_reg)
                        begin
                            hv_reg <= span;
                            done_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (span == phash_reg)
                        begin
                            pos_reg <= lo_reg[13:0];
                            done_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (next_lo + plen_ext <= len_ext)
                        begin
                            lo_reg <= next_lo;
                            hi_reg <= hi_reg + CW'(1);
                            ha_reg <= next_lo[AW-1:0];
                            state_reg <= S_RD_A;
                        end
                        else
                        begin
                            pos_reg <= '1;
                            done_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign hash_value = hv_reg;
    assign position = pos_reg;
    assign error = err_reg;
endmodule

// ===== rtl/rolling_hash_substring_engine.sv =====
// Top level: base register, APB port, command queue and executor.
// Clears and errors finish straight from idle; appends, queries and finds wait on the
// shared iterative 61-bit modular multiplier and the store reads, a find repeating
// the reads and the multiply for each further start position scanned.
// A two-word queue lets start be taken while the executor works; busy marks it full.
// Reset clears lengths and the pattern hash and restores the default base; stores need
// no clearing pass.
module rolling_hash_substring_engine #(
    parameter int MAX_LEN = rhse_pkg::MAX_LEN_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  ch,
    input  logic [12:0] pos_l,
    input  logic [12:0] pos_r,
    output logic        done,
    output logic [60:0] hash_value,
    output logic signed [13:0] position,
    output logic        error
);
    import rhse_pkg::*;

    logic [60:0] base_reg;
    logic [60:0] base_eff;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    // Base register; the value equal to the modulus acts as zero.
    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? {3'd0, base_reg} : 64'd0;
    assign base_eff = (base_reg == MOD61) ? 61'd0 : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && paddr == 4'd0)
        begin
            base_reg <= pwdata[60:0];
        end
    end

    rhse_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .ch(ch),
        .pos_l(pos_l), .pos_r(pos_r), .busy(busy), .q_valid(q_valid),
        .q_item(q_item), .q_pop(q_pop)
    );

    rhse_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .base(base_eff), .q_valid(q_valid),
        .q_item(q_item), .q_pop(q_pop), .done(done), .hash_value(hash_value),
        .position(position), .error(error)
    );
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the rolling hash substring engine.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhse_pkg::*;

    localparam int MAXL = MAX_LEN_DEFAULT;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [3:0] ADDR_HASH_BASE = 4'd0;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  ch;
        logic [12:0] lo;
        logic [12:0] hi;
    } word_t;

    typedef struct {
        logic [60:0] hash;
        logic [13:0] pos;
        logic        err;
    } hash_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start, busy;
    logic [2:0]  cmd;
    logic [7:0]  ch;
    logic [12:0] pos_l, pos_r;
    logic        done;
    logic [60:0] hash_value;
    logic signed [13:0] position;
    logic        error;

    rolling_hash_substring_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .cmd(cmd), .ch(ch), .pos_l(pos_l), .pos_r(pos_r),
        .done(done), .hash_value(hash_value), .position(position), .error(error)
    );

    // Words waiting to be sent and hash results still owed by the block.
    word_t      words_pending[$];
    hash_word_t hashes_due[$];
    int         fail_count = 0;
    int         gap_left;

    // Shadow of the block's state, advanced as each word is accepted.
    logic [60:0] prefix_tbl [0:MAXL];
    logic [60:0] power_tbl [0:MAXL];
    int          text_len;
    int          pat_len;
    logic [60:0] pat_hash;
    logic [60:0] base_reg;

    // Text as the stimulus generator expects it to be when its words run.
    logic [7:0]  gen_text [0:MAXL-1];
    int          gen_len;
    int          gen_plen;

    function automatic logic [60:0] mod_mul(input logic [60:0] a, input logic [60:0] b);
        logic [121:0] p;
        p = a * b;
        return 61'(p % MOD61);
    endfunction

    function automatic logic [60:0] add_byte(input logic [60:0] a, input logic [7:0] b);
        logic [61:0] s;
        s = a + b;
        if (s >= MOD61)
            s = s - MOD61;
        return s[60:0];
    endfunction

    function automatic logic [60:0] span_hash(input int l, input int r);
        logic [61:0] s;
        s = prefix_tbl[r] + (MOD61 - mod_mul(prefix_tbl[l], power_tbl[r - l]));
        if (s >= MOD61)
            s = s - MOD61;
        return s[60:0];
    endfunction

    // Advance the shadow state by one accepted word and queue its result.
    task automatic predict_hash(input logic [2:0] op, input logic [7:0] b,
                                input logic [12:0] lo, input logic [12:0] hi);
        hash_word_t res;
        logic [60:0] bv;
        int l;
        int r;
        int i;
        res.hash = '0;
        res.pos = '0;
        res.err = 1'b0;
        bv = (base_reg == MOD61) ? 61'd0 : base_reg;
        l = lo;
        r = hi;
        case (op)
            CMD_APPEND_TEXT:
                if (text_len >= MAXL)
                    res.err = 1'b1;
                else
                begin
                    prefix_tbl[text_len + 1] = add_byte(mod_mul(prefix_tbl[text_len], bv), b);
                    power_tbl[text_len + 1] = mod_mul(power_tbl[text_len], bv);
                    text_len++;
                    res.hash = prefix_tbl[text_len];
                end
            CMD_QUERY:
                if (l <= r && r <= text_len)
                    res.hash = span_hash(l, r);
                else
                    res.err = 1'b1;
            CMD_APPEND_PAT:
                if (pat_len >= MAXL)
                    res.err = 1'b1;
                else
                begin
                    pat_hash = add_byte(mod_mul(pat_hash, bv), b);
                    pat_len++;
                    res.hash = pat_hash;
                end
            CMD_FIND:
            begin
                res.pos = '1;
                for (i = l; i + pat_len <= text_len; i++)
                begin
                    if (span_hash(i, i + pat_len) == pat_hash)
                    begin
                        res.pos = 14'(i);
                        break;
                    end
                end
            end
            CMD_CLEAR_PAT:
            begin
                pat_len = 0;
                pat_hash = '0;
            end
            CMD_CLEAR_ALL:
            begin
                text_len = 0;
                pat_len = 0;
                pat_hash = '0;
            end
            default:
                res.err = 1'b1;
        endcase
        hashes_due.push_back(res);
    endtask

    // Queue one word and keep the generator's view of the text in step.
    task automatic push_word(input logic [2:0] op, input logic [7:0] b,
                             input logic [12:0] lo, input logic [12:0] hi);
        word_t w;
        w.op = op;
        w.ch = b;
        w.lo = lo;
        w.hi = hi;
        words_pending.push_back(w);
        case (op)
            CMD_APPEND_TEXT:
                if (gen_len < MAXL)
                begin
                    gen_text[gen_len] = b;
                    gen_len++;
                end
            CMD_APPEND_PAT:
                if (gen_plen < MAXL)
                    gen_plen++;
            CMD_CLEAR_PAT:
                gen_plen = 0;
            CMD_CLEAR_ALL:
            begin
                gen_len = 0;
                gen_plen = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: presents the oldest pending word and predicts it once taken.
    always @(posedge clk or negedge rst_n)
    begin
        logic taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= CMD_APPEND_TEXT;
            ch <= '0;
            pos_l <= '0;
            pos_r <= '0;
            gap_left <= 0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_hash(cmd, ch, pos_l, pos_r);
                void'(words_pending.pop_front());
            end
            if (taken || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (words_pending.size() > 0)
                begin
                    start <= 1'b1;
                    cmd <= words_pending[0].op;
                    ch <= words_pending[0].ch;
                    pos_l <= words_pending[0].lo;
                    pos_r <= words_pending[0].hi;
                    gap_left <= pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest expected word.
    always @(posedge clk)
    begin
        hash_word_t exp_w;
        if (rst_n && done)
        begin
            if (hashes_due.size() == 0)
            begin
                $error("unexpected result word: hash_value %h position %h error %b",
                       hash_value, position, error);
                fail_count++;
            end
            else
            begin
                exp_w = hashes_due.pop_front();
                if (hash_value !== exp_w.hash)
                begin
                    $error("hash_value expected %h actual %h", exp_w.hash, hash_value);
                    fail_count++;
                end
                if (position !== exp_w.pos)
                begin
                    $error("position expected %h actual %h", exp_w.pos, position);
                    fail_count++;
                end
                if (error !== exp_w.err)
                begin
                    $error("error expected %b actual %b", exp_w.err, error);
                    fail_count++;
                end
            end
        end
    end

    // Wait until every queued word has been sent and answered.
    task automatic wait_idle();
        while (words_pending.size() != 0 || start || hashes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write the base register, then read it back.
    task automatic write_base(input logic [60:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_HASH_BASE;
        pwdata <= {3'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        base_reg = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[60:0] !== value)
        begin
            $error("hash_base expected %h actual %h", value, prdata[60:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed sessions: build text, query it, search for a piece of it.
    task automatic random_words(input int count);
        int sent;
        int k;
        int j;
        int s;
        int m;
        int lo;
        bit narrow;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7 || gen_len > 200)
            begin
                push_word(CMD_CLEAR_ALL, 8'($urandom), 13'($urandom), 13'($urandom));
                sent++;
            end
            narrow = $urandom_range(0, 1);
            k = $urandom_range(1, 24);
            for (j = 0; j < k; j++)
                push_word(CMD_APPEND_TEXT,
                          narrow ? 8'($urandom_range(0, 2)) : 8'($urandom), '0, '0);
            sent += k;
            for (j = 0; j < 2; j++)
            begin
                lo = $urandom_range(0, gen_len);
                push_word(CMD_QUERY, 8'($urandom), 13'(lo), 13'($urandom_range(lo, gen_len)));
            end
            push_word(CMD_CLEAR_PAT, '0, '0, '0);
            s = $urandom_range(0, gen_len - 1);
            m = $urandom_range(1, (gen_len - s < 6) ? gen_len - s : 6);
            for (j = 0; j < m; j++)
                push_word(CMD_APPEND_PAT, gen_text[s + j], '0, '0);
            push_word(CMD_FIND, '0, ($urandom_range(0, 7) == 0) ? 13'($urandom)
                      : 13'($urandom_range(0, gen_len)), '0);
            sent += m + 4;
            // Noise: any code with any field values.
            for (j = 0; j < 2; j++)
                push_word(3'($urandom), 8'($urandom), 13'($urandom), 13'($urandom));
            sent += 2;
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        int j;
        logic [60:0] rnd_base;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        prefix_tbl[0] = '0;
        power_tbl[0] = 61'd1;
        text_len = 0;
        pat_len = 0;
        pat_hash = '0;
        base_reg = BASE_RESET;
        gen_len = 0;
        gen_plen = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: byte extremes, ranges, empty pattern, unknown codes.
        push_word(CMD_APPEND_TEXT, 8'h00, '0, '0);
        push_word(CMD_APPEND_TEXT, 8'hFF, '0, '0);
        push_word(CMD_APPEND_TEXT, 8'h5A, '0, '0);
        push_word(CMD_APPEND_TEXT, 8'hA5, '0, '0);
        push_word(CMD_QUERY, '0, 13'd0, 13'd0);
        push_word(CMD_QUERY, '0, 13'd0, 13'd4);
        push_word(CMD_QUERY, '0, 13'd1, 13'd3);
        push_word(CMD_QUERY, '0, 13'd3, 13'd2);
        push_word(CMD_QUERY, '0, 13'd0, 13'd5);
        push_word(CMD_QUERY, '0, 13'h1FFF, 13'h1FFF);
        push_word(CMD_APPEND_PAT, 8'hFF, '0, '0);
        push_word(CMD_APPEND_PAT, 8'h5A, '0, '0);
        push_word(CMD_FIND, '0, 13'd0, '0);
        push_word(CMD_FIND, '0, 13'd2, '0);
        push_word(CMD_FIND, '0, 13'd4096, '0);
        push_word(CMD_CLEAR_PAT, '0, '0, '0);
        push_word(CMD_FIND, '0, 13'd4, '0);
        push_word(CMD_FIND, '0, 13'd5, '0);
        push_word(CMD_UNUSED_LO, 8'hFF, 13'h1FFF, 13'h1FFF);
        push_word(CMD_UNUSED_HI, '0, '0, '0);
        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        push_word(CMD_QUERY, '0, 13'd0, 13'd0);
        random_words(120);
        wait_idle();

        // Base rewrite with text still stored, then carry on without a clear.
        write_base(61'd2);
        for (j = 0; j < 5; j++)
            push_word(CMD_APPEND_TEXT, 8'($urandom), '0, '0);
        push_word(CMD_QUERY, '0, 13'd0, 13'(gen_len));
        push_word(CMD_FIND, '0, 13'd0, '0);
        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        random_words(120);
        wait_idle();

        write_base(MOD61 - 61'd1);
        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        random_words(120);
        wait_idle();

        // The modulus itself acts as a zero base.
        write_base(MOD61);
        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        random_words(100);
        wait_idle();

        rnd_base = 61'($urandom_range(2, 32'hFFFF_FFFF)) | (61'($urandom) << 29);
        if (rnd_base >= MOD61 || rnd_base < 61'd2)
            rnd_base = 61'd12345;
        write_base(rnd_base);
        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        random_words(120);

        push_word(CMD_CLEAR_ALL, '0, '0, '0);
        random_words(60);

        wait_idle();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
